// ===== rtl/itrd_pkg.sv =====
// Shared types, constants and the digit encoder for the radix digit converter.
`default_nettype none

package itrd_pkg;

    localparam int unsigned RADIX_W  = 6;
    localparam int unsigned REM_W    = 6;
    localparam int unsigned POS_W    = 5;
    localparam int unsigned CHAR_W   = 8;

    localparam logic [RADIX_W-1:0] RADIX_MIN = 6'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX = 6'd36;

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;  // '0'
    localparam logic [CHAR_W-1:0] CHAR_A     = 8'h41;  // 'A'
    localparam logic [CHAR_W-1:0] CHAR_NONE  = 8'h00;
    localparam logic [REM_W-1:0]  DEC_LIMIT  = 6'd9;
    localparam logic [REM_W-1:0]  ALPHA_BASE = 6'd10;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_OUT
    } itrd_state_t;

    // Status the divider hands back to the sequencer.
    typedef struct packed {
        logic             done;
        logic [REM_W-1:0] rem;
    } itrd_div_stat_t;

    // Map a remainder 0..35 to '0'..'9', 'A'..'Z'.
    function automatic logic [CHAR_W-1:0] itrd_digit_char(input logic [REM_W-1:0] rem);
        logic [CHAR_W-1:0] ch;
        if (rem > DEC_LIMIT) begin
            ch = CHAR_A + CHAR_W'(rem - ALPHA_BASE);
        end else begin
            ch = CHAR_ZERO + CHAR_W'(rem);
        end
        return ch;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/itrd_div.sv =====
// Restoring divider: one quotient bit per cycle, small divisor.
`default_nettype none

module itrd_div #(
    parameter int unsigned NUM_BITS = 31
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         start,
    input  wire logic [NUM_BITS-1:0]          dividend,
    input  wire logic [itrd_pkg::RADIX_W-1:0] divisor,
    output logic      [NUM_BITS-1:0]          quotient,
    output itrd_pkg::itrd_div_stat_t          stat
);
    import itrd_pkg::*;

    localparam int unsigned CNT_W = $clog2(NUM_BITS + 1);
    localparam int unsigned PR_W  = RADIX_W + 1;

    logic [NUM_BITS-1:0] dvd_reg,  dvd_next;
    logic [PR_W-1:0]     rem_reg,  rem_next;
    logic [RADIX_W-1:0]  dvs_reg,  dvs_next;
    logic [CNT_W-1:0]    cnt_reg,  cnt_next;
    logic                busy_reg, busy_next;
    logic                done_reg, done_next;

    logic [PR_W-1:0]     rem_sh;
    logic [PR_W-1:0]     rem_sub;
    logic                q_bit;

    // Shift in the next dividend bit, trial-subtract the divisor.
    always_comb begin
        rem_sh  = {rem_reg[PR_W-2:0], dvd_reg[NUM_BITS-1]};
        rem_sub = rem_sh - {1'b0, dvs_reg};
        q_bit   = (rem_sh >= {1'b0, dvs_reg});
    end

    always_comb begin
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            dvd_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
            cnt_next  = CNT_W'(NUM_BITS);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            dvd_next = {dvd_reg[NUM_BITS-2:0], q_bit};
            rem_next = q_bit ? rem_sub : rem_sh;
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign quotient  = dvd_reg;
    assign stat.done = done_reg;
    assign stat.rem  = rem_reg[REM_W-1:0];

endmodule

`default_nettype wire

// ===== rtl/int_to_radix_digits_unit.sv =====
// Top level: integer to base-N ASCII digit converter, sequencer and result register.
// ---------------------------------------------------------------------------
// Usage
//   Input channel (s_valid/s_ready): one beat carries s_number and s_radix.
//   Result channel (m_valid/m_ready): one beat per digit, least significant
//   digit first, with its position; m_is_last marks the final beat of an
//   input. A zero number gives a single beat with m_empty_res set; a radix
//   outside 2..36 gives a single beat with m_bad_radix set (checked first).
// Timing
//   Each digit is one pass of a shared restoring divider that resolves one
//   quotient bit per cycle. s_ready is high only while the block is idle:
//   one input is converted at a time.
// Reset
//   aresetn (synchronous, active low) returns the sequencer to idle and
//   drops any conversion in flight and any result beat not yet taken.
// Stall
//   While m_ready is low the result beat holds steady and the divider waits;
//   the next digit starts in the cycle the beat is taken.
// ---------------------------------------------------------------------------
`default_nettype none

module int_to_radix_digits_unit #(
    parameter int unsigned NUM_BITS = 31
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire logic [NUM_BITS-1:0]          s_number,
    input  wire logic [itrd_pkg::RADIX_W-1:0] s_radix,
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output logic      [itrd_pkg::CHAR_W-1:0]  m_digit_char,
    output logic      [itrd_pkg::POS_W-1:0]   m_position,
    output logic                              m_is_last,
    output logic                              m_empty_res,
    output logic                              m_bad_radix
);
    import itrd_pkg::*;

    itrd_state_t         state_reg, state_next;

    // Conversion in progress
    logic [NUM_BITS-1:0] quot_reg,  quot_next;
    logic [RADIX_W-1:0]  radix_reg, radix_next;
    logic [POS_W-1:0]    pos_reg,   pos_next;

    // Result beat register
    logic [CHAR_W-1:0]   char_reg,  char_next;
    logic [POS_W-1:0]    opos_reg,  opos_next;
    logic                last_reg,  last_next;
    logic                empty_reg, empty_next;
    logic                bad_reg,   bad_next;

    // Divider hookup
    logic                div_start;
    logic [NUM_BITS-1:0] div_dividend;
    logic [RADIX_W-1:0]  div_divisor;
    logic [NUM_BITS-1:0] div_quot;
    itrd_div_stat_t      div_stat;

    logic                radix_ok;
    logic                num_zero;
    logic                in_beat;

    assign radix_ok = s_radix inside {[RADIX_MIN:RADIX_MAX]};
    assign num_zero = (s_number == '0);
    assign in_beat  = s_valid && (state_reg == ST_IDLE);

    itrd_div #(
        .NUM_BITS (NUM_BITS)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quotient (div_quot),
        .stat     (div_stat)
    );

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = (radix_ok && !num_zero) ? ST_DIV : ST_OUT;
                end
            end
            ST_DIV: begin
                if (div_stat.done) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (m_ready) begin
                    state_next = last_reg ? ST_IDLE : ST_DIV;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Control outputs
    always_comb begin
        s_ready      = 1'b0;
        m_valid      = 1'b0;
        div_start    = 1'b0;
        div_dividend = quot_reg;
        div_divisor  = radix_reg;
        case (state_reg)
            ST_IDLE: begin
                s_ready      = 1'b1;
                div_start    = s_valid && radix_ok && !num_zero;
                div_dividend = s_number;
                div_divisor  = s_radix;
            end
            ST_DIV: begin
                // Wait for the divider.
            end
            ST_OUT: begin
                m_valid   = 1'b1;
                div_start = m_ready && !last_reg;
            end
            default: begin
            end
        endcase
    end

    // Datapath next values
    always_comb begin
        quot_next  = quot_reg;
        radix_next = radix_reg;
        pos_next   = pos_reg;
        char_next  = char_reg;
        opos_next  = opos_reg;
        last_next  = last_reg;
        empty_next = empty_reg;
        bad_next   = bad_reg;
        if (in_beat) begin
            radix_next = s_radix;
            pos_next   = '0;
            char_next  = CHAR_NONE;
            opos_next  = '0;
            last_next  = 1'b1;
            empty_next = radix_ok && num_zero;
            bad_next   = !radix_ok;
        end else if ((state_reg == ST_DIV) && div_stat.done) begin
            // Capture the digit, advance the position.
            quot_next  = div_quot;
            char_next  = itrd_digit_char(div_stat.rem);
            opos_next  = pos_reg;
            last_next  = (div_quot == '0);
            empty_next = 1'b0;
            bad_next   = 1'b0;
            pos_next   = pos_reg + POS_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        quot_reg  <= quot_next;
        radix_reg <= radix_next;
        pos_reg   <= pos_next;
        char_reg  <= char_next;
        opos_reg  <= opos_next;
        last_reg  <= last_next;
        empty_reg <= empty_next;
        bad_reg   <= bad_next;
    end

    assign m_digit_char = char_reg;
    assign m_position   = opos_reg;
    assign m_is_last    = last_reg;
    assign m_empty_res  = empty_reg;
    assign m_bad_radix  = bad_reg;

endmodule

`default_nettype wire

// ===== rtl/itrd_checker.sv =====
// Port-level checks for the radix digit converter, bound to the top level.
`default_nettype none

module itrd_checker (
    input wire logic                        aclk,
    input wire logic                        aresetn,
    input wire logic                        s_valid,
    input wire logic                        s_ready,
    input wire logic                        m_valid,
    input wire logic                        m_ready,
    input wire logic [itrd_pkg::CHAR_W-1:0] m_digit_char,
    input wire logic [itrd_pkg::POS_W-1:0]  m_position,
    input wire logic                        m_is_last,
    input wire logic                        m_empty_res,
    input wire logic                        m_bad_radix
);
    import itrd_pkg::*;

    // A stalled result beat holds.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_digit_char)
            && $stable(m_position) && $stable(m_is_last)
            && $stable(m_empty_res) && $stable(m_bad_radix))
        else $error("result beat changed while stalled");

    // One input at a time: never ready while a result is pending.
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !m_valid)
        else $error("input ready while a result is pending");

    // Special results stand alone and carry no digit.
    a_special_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_empty_res || m_bad_radix) |->
            m_is_last && (m_digit_char == CHAR_NONE) && (m_position == '0)
            && !(m_empty_res && m_bad_radix))
        else $error("malformed empty or bad-radix result");

    // Digit beats carry an upper-case alphanumeric character.
    a_digit_char: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_empty_res && !m_bad_radix |->
            ((m_digit_char >= CHAR_ZERO) && (m_digit_char <= 8'h39))
            || ((m_digit_char >= CHAR_A) && (m_digit_char <= 8'h5A)))
        else $error("digit character out of range");

    // After an input beat, the block stays busy in the next cycle.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input ready right after an accepted beat");

endmodule

bind int_to_radix_digits_unit itrd_checker u_itrd_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_valid      (s_valid),
    .s_ready      (s_ready),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_digit_char (m_digit_char),
    .m_position   (m_position),
    .m_is_last    (m_is_last),
    .m_empty_res  (m_empty_res),
    .m_bad_radix  (m_bad_radix)
);

`default_nettype wire

// ===== dv/tb_int_to_radix_digits_unit.sv =====
// Self-checking testbench for the integer to base-N ASCII digit converter.
`default_nettype none

module tb_int_to_radix_digits_unit;

    timeunit 1ns;
    timeprecision 1ps;

    import itrd_pkg::*;

    localparam int unsigned NUM_BITS     = 31;
    localparam int unsigned CLK_HALF     = 4;
    localparam int unsigned RANDOM_ITEMS = 100;
    // Tail slack, sized from the time one digit takes to convert.
    localparam int unsigned TAIL_CYCLES  = 4 * (NUM_BITS + 2);
    localparam int unsigned MAX_REPORTS  = 10;
    // Worst case is about 31 digits with a long result stall on each,
    // for some 125 inputs; this is several times that.
    localparam longint unsigned TIMEOUT_NS = 64'd10_000_000;

    localparam logic [NUM_BITS-1:0] NUMBER_MAX = {NUM_BITS{1'b1}};

    // One result beat, field for field as the result channel carries it.
    typedef struct packed {
        logic [CHAR_W-1:0] digit_char;
        logic [POS_W-1:0]  position;
        logic              is_last;
        logic              empty_res;
        logic              bad_radix;
    } digit_beat_t;

    // One row of the directed table; typed rows carry their single result.
    typedef struct {
        logic [NUM_BITS-1:0] number;
        logic [RADIX_W-1:0]  radix;
        bit                  typed;
        digit_beat_t         beat;
    } stim_row_t;

    logic                aclk    = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    logic [NUM_BITS-1:0] s_number = '0;
    logic [RADIX_W-1:0]  s_radix  = '0;
    logic                m_valid;
    logic                m_ready  = 1'b0;
    logic [CHAR_W-1:0]   m_digit_char;
    logic [POS_W-1:0]    m_position;
    logic                m_is_last;
    logic                m_empty_res;
    logic                m_bad_radix;

    // Travels with the input beat: use the typed result instead of predicting.
    bit                  typed_pending = 1'b0;
    digit_beat_t         typed_beat    = '0;

    // Turns idling off on both channels for a stretch of items.
    bit                  steady_phase  = 1'b0;

    digit_beat_t         expected_digits[$];
    stim_row_t           directed_rows[$];
    int unsigned         error_count = 0;

    int_to_radix_digits_unit #(
        .NUM_BITS (NUM_BITS)
    ) DUT (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_number     (s_number),
        .s_radix      (s_radix),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_digit_char (m_digit_char),
        .m_position   (m_position),
        .m_is_last    (m_is_last),
        .m_empty_res  (m_empty_res),
        .m_bad_radix  (m_bad_radix)
    );

    always #(CLK_HALF) aclk = ~aclk;

    // Gap length for either channel: mostly none or short, now and then long.
    function automatic int idle_cycles();
        int r;
        r = $urandom_range(0, 99);
        if (steady_phase || r < 45) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 96) return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    // Work out every digit beat one input causes and queue them in order.
    function automatic void predict_digits(input logic [NUM_BITS-1:0] num,
                                           input logic [RADIX_W-1:0]  rad);
        logic [NUM_BITS-1:0] rest;
        logic [NUM_BITS-1:0] rem;
        logic [POS_W-1:0]    pos;
        digit_beat_t         beat;
        beat = '0;
        // Radix out of range wins over a zero number.
        if (rad < RADIX_MIN || rad > RADIX_MAX) begin
            beat.digit_char = CHAR_NONE;
            beat.is_last    = 1'b1;
            beat.bad_radix  = 1'b1;
            expected_digits.push_back(beat);
            return;
        end
        // Zero converts to the empty string: one flagged beat, no digit.
        if (num == '0) begin
            beat.digit_char = CHAR_NONE;
            beat.is_last    = 1'b1;
            beat.empty_res  = 1'b1;
            expected_digits.push_back(beat);
            return;
        end
        rest = num;
        pos  = '0;
        do begin
            rem  = rest % NUM_BITS'(rad);
            rest = rest / NUM_BITS'(rad);
            beat.digit_char = (rem < 10) ? CHAR_ZERO + CHAR_W'(rem)
                                         : CHAR_A + CHAR_W'(rem - 10);
            beat.position   = pos;
            beat.is_last    = (rest == '0);
            expected_digits.push_back(beat);
            pos = pos + 1'b1;
        end while (rest != '0);
    endfunction

    function automatic void add_row(input logic [NUM_BITS-1:0] num,
                                    input logic [RADIX_W-1:0]  rad,
                                    input bit                  typed,
                                    input logic [CHAR_W-1:0]   ch,
                                    input logic                empty,
                                    input logic                bad);
        stim_row_t row;
        row.number           = num;
        row.radix            = rad;
        row.typed            = typed;
        row.beat.digit_char  = ch;
        row.beat.position    = '0;
        row.beat.is_last     = 1'b1;
        row.beat.empty_res   = empty;
        row.beat.bad_radix   = bad;
        directed_rows.push_back(row);
    endfunction

    function automatic void report_error(input string what,
                                         input digit_beat_t want,
                                         input digit_beat_t got);
        error_count++;
        if (error_count <= MAX_REPORTS) begin
            $display("%0t %s: exp char=%h pos=%0d last=%b empty=%b bad=%b",
                     $realtime, what, want.digit_char, want.position,
                     want.is_last, want.empty_res, want.bad_radix);
            $display("%0t %s: got char=%h pos=%0d last=%b empty=%b bad=%b",
                     $realtime, what, got.digit_char, got.position,
                     got.is_last, got.empty_res, got.bad_radix);
        end
    endfunction

    // Raise one input beat after a random gap and hold it until accepted.
    // Return at the accepting edge so the caller can chain the next beat.
    task automatic send_number(input logic [NUM_BITS-1:0] num,
                               input logic [RADIX_W-1:0]  rad,
                               input bit                  typed,
                               input digit_beat_t         beat);
        int gap;
        gap = idle_cycles();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_number      <= num;
        s_radix       <= rad;
        typed_pending <= typed;
        typed_beat    <= beat;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // Drop valid, then hold off until every queued digit beat has been taken.
    task automatic wait_drained(input int unsigned extra_cycles);
        s_valid <= 1'b0;
        @(posedge aclk);
        while (expected_digits.size() != 0) @(posedge aclk);
        repeat (extra_cycles) @(posedge aclk);
    endtask

    // Scoreboard: predict on every accepted input beat, check every taken
    // result beat against the oldest prediction. All sampling is at the
    // rising edge, so only pre-edge values are seen.
    always @(posedge aclk) begin
        digit_beat_t got;
        digit_beat_t want;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                if (typed_pending) begin
                    expected_digits.push_back(typed_beat);
                end else begin
                    predict_digits(s_number, s_radix);
                end
            end
            if (m_valid && m_ready) begin
                got.digit_char = m_digit_char;
                got.position   = m_position;
                got.is_last    = m_is_last;
                got.empty_res  = m_empty_res;
                got.bad_radix  = m_bad_radix;
                if (expected_digits.size() == 0) begin
                    report_error("unexpected beat", '0, got);
                end else begin
                    want = expected_digits.pop_front();
                    if (got.digit_char !== want.digit_char ||
                        got.position   !== want.position   ||
                        got.is_last    !== want.is_last    ||
                        got.empty_res  !== want.empty_res  ||
                        got.bad_radix  !== want.bad_radix) begin
                        report_error("mismatch", want, got);
                    end
                end
            end
        end
    end

    // Result side: ready for a random run of cycles, then stall at random.
    initial begin
        int run_len;
        int stall_len;
        @(posedge aclk);
        forever begin
            run_len = $urandom_range(1, 16);
            m_ready <= 1'b1;
            repeat (run_len) @(posedge aclk);
            stall_len = idle_cycles();
            if (stall_len > 0) begin
                m_ready <= 1'b0;
                repeat (stall_len) @(posedge aclk);
            end
        end
    end

    // Input side: reset, directed table, random part, drain, verdict.
    initial begin
        logic [NUM_BITS-1:0] num;
        logic [RADIX_W-1:0]  rad;
        int unsigned         pick;

        // Bad radix at every edge of the legal range, ahead of a zero number.
        add_row(5,          0,  1'b1, CHAR_NONE, 1'b0, 1'b1);
        add_row(0,          1,  1'b1, CHAR_NONE, 1'b0, 1'b1);
        add_row(100,        37, 1'b1, CHAR_NONE, 1'b0, 1'b1);
        add_row(NUMBER_MAX, 63, 1'b1, CHAR_NONE, 1'b0, 1'b1);
        // Zero gives the empty beat in any legal radix.
        add_row(0,          2,  1'b1, CHAR_NONE, 1'b1, 1'b0);
        add_row(0,          10, 1'b1, CHAR_NONE, 1'b1, 1'b0);
        add_row(0,          36, 1'b1, CHAR_NONE, 1'b1, 1'b0);
        // Single digits at the ends of the numeric and alphabetic ranges.
        add_row(1,          2,  1'b1, "1", 1'b0, 1'b0);
        add_row(9,          10, 1'b1, "9", 1'b0, 1'b0);
        add_row(10,         36, 1'b1, "A", 1'b0, 1'b0);
        add_row(35,         36, 1'b1, "Z", 1'b0, 1'b0);
        add_row(15,         16, 1'b1, "F", 1'b0, 1'b0);
        // Multi-digit conversions go through the predictor.
        add_row(NUMBER_MAX, 2,  1'b0, '0, 1'b0, 1'b0);
        add_row(NUMBER_MAX, 3,  1'b0, '0, 1'b0, 1'b0);
        add_row(NUMBER_MAX, 16, 1'b0, '0, 1'b0, 1'b0);
        add_row(NUMBER_MAX, 35, 1'b0, '0, 1'b0, 1'b0);
        add_row(NUMBER_MAX, 36, 1'b0, '0, 1'b0, 1'b0);
        add_row(36,         36, 1'b0, '0, 1'b0, 1'b0);
        add_row(31'h4000_0000, 2, 1'b0, '0, 1'b0, 1'b0);
        add_row(31'h5555_5555, 4, 1'b0, '0, 1'b0, 1'b0);
        add_row(12345,      10, 1'b0, '0, 1'b0, 1'b0);
        add_row(255,        16, 1'b0, '0, 1'b0, 1'b0);
        add_row(1295,       36, 1'b0, '0, 1'b0, 1'b0);

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Walk the table with idling off for the first few rows.
        steady_phase = 1'b1;
        foreach (directed_rows[i]) begin
            if (i == 6) steady_phase = 1'b0;
            send_number(directed_rows[i].number, directed_rows[i].radix,
                        directed_rows[i].typed, directed_rows[i].beat);
        end

        // Hold off the sender until the block has emptied out.
        wait_drained(2);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 16 == 0) steady_phase = ($urandom_range(0, 3) == 0);
            pick = $urandom_range(0, 9);
            case (pick)
                0:       num = '0;
                1:       num = NUM_BITS'($urandom_range(1, 40));
                2:       num = NUMBER_MAX;
                3:       num = NUM_BITS'(1) << $urandom_range(0, NUM_BITS - 1);
                default: num = NUM_BITS'($urandom);
            endcase
            pick = $urandom_range(0, 9);
            case (pick)
                0: begin
                    if ($urandom_range(0, 3) == 0) begin
                        rad = RADIX_W'($urandom_range(0, 1));
                    end else begin
                        rad = RADIX_W'($urandom_range(37, 63));
                    end
                end
                1:       rad = RADIX_MIN;
                2:       rad = RADIX_MAX;
                default: rad = RADIX_W'($urandom_range(2, 36));
            endcase
            send_number(num, rad, 1'b0, '0);
            // Now and then let the sender wait for a full drain.
            if ($urandom_range(0, 19) == 0) wait_drained(2);
        end

        wait_drained(TAIL_CYCLES);

        if (expected_digits.size() != 0) begin
            report_error("missing beat", expected_digits[0], '0);
            error_count += expected_digits.size() - 1;
        end

        if (error_count == 0) begin
            $display("tb_int_to_radix_digits_unit: done, clean");
        end else begin
            $display("tb_int_to_radix_digits_unit: done, errors");
        end
        $finish;
    end

    // Watchdog: end the run if the handshakes never complete.
    initial begin
        #(TIMEOUT_NS);
        $display("tb_int_to_radix_digits_unit: done, errors");
        $finish;
    end

endmodule

`default_nettype wire
